[design/sbda_pkg.sv]
package sbda_pkg;

    // Width of the signed input word.
    localparam int VALUE_BITS = 32;

    // Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1).
    // VALUE_BITS*3/10 tracks VALUE_BITS*log10(2) closely enough over 8..64 bits.
    localparam int DIGIT_SLOTS = (VALUE_BITS * 3) / 10 + 1;
    localparam int BCD_BITS    = 4 * DIGIT_SLOTS;
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W   = $clog2(DIGIT_SLOTS + 1);

    // ASCII codes.
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Operations of the shared BCD shift unit.
    typedef enum logic [1:0] {
        BCD_HOLD   = 2'd0,
        BCD_LOAD   = 2'd1,
        BCD_DABBLE = 2'd2,
        BCD_SHIFT  = 2'd3
    } bcd_op_t;

    // Status returned by the BCD unit to the sequencer.
    typedef struct packed {
        logic [3:0] top_digit;
        logic       top_zero;
    } bcd_stat_t;

endpackage

[design/sbda_bcd_core.sv]
module sbda_bcd_core (
    input  logic                             clk,
    input  sbda_pkg::bcd_op_t                op,
    input  logic [sbda_pkg::VALUE_BITS-1:0]  mag,
    output sbda_pkg::bcd_stat_t              stat
);
    import sbda_pkg::*;

    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [BCD_BITS-1:0]   bcd_reg;
    logic [BCD_BITS-1:0]   bcd_next;
    logic [BCD_BITS-1:0]   bcd_adj;

    // Add three to every digit of five or more before the next doubling.
    always_comb
    begin
        for (int d = 0; d < DIGIT_SLOTS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    // One step of the shared unit per cycle, chosen by the sequencer.
    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        case (op)
            BCD_LOAD:
            begin
                bin_next = mag;
                bcd_next = '0;
            end
            BCD_DABBLE:
            begin
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
                bcd_next = {bcd_adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
            end
            BCD_SHIFT:
            begin
                bcd_next = {bcd_reg[BCD_BITS-5:0], 4'd0};
            end
            default:
            begin
                bin_next = bin_reg;
                bcd_next = bcd_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // The most significant digit is always the one presented.
    assign stat.top_digit = bcd_reg[BCD_BITS-1 -: 4];
    assign stat.top_zero  = (bcd_reg[BCD_BITS-1 -: 4] == 4'd0);

endmodule

[design/signed_binary_to_decimal_ascii.sv]
// Signed binary to decimal ASCII converter.
// Pulse start with a signed value while busy is low; that edge accepts the
// beat. The block then raises busy and emits the decimal text of the value,
// one ASCII character at a time on character, each marked by a one-cycle
// valid pulse. A negative value begins with '-', zero gives a single '0',
// and no leading zeros appear. last is high with the final character.
// Conversion runs a shift-and-add-three unit over the magnitude, one bit per
// cycle over all VALUE_BITS bits, then shifts the digits out of the BCD
// register one per cycle, first dropping the leading zeros.
// A negative value shows its minus sign once the conversion ends, before
// any digit. The digits come out on consecutive cycles; after a minus
// sign there is a gap, during which the leading zeros are skipped.
// A new beat may be started in the cycle that shows the last character.
// The receiver cannot stall the output: every valid cycle must be taken.
// Reset clears the sequencer and the valid strobe; the block is then idle.
module signed_binary_to_decimal_ascii (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [sbda_pkg::VALUE_BITS-1:0] value,
    output logic                                   valid,
    output logic [7:0]                             character,
    output logic                                   last
);
    import sbda_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SIGN = 5'b00100,
        ST_SKIP = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [BIT_CNT_W-1:0]  bit_cnt_next;
    logic [DIG_CNT_W-1:0]  dig_cnt_reg;
    logic [DIG_CNT_W-1:0]  dig_cnt_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic [7:0]            character_reg;
    logic [7:0]            character_next;
    logic                  last_reg;
    logic                  last_next;
    bcd_op_t               op;
    bcd_stat_t             stat;
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic                  accept;
    logic                  one_left;

    // Unsigned magnitude; the most negative value maps to 2^(VALUE_BITS-1).
    assign raw      = $unsigned(value);
    assign mag      = value[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
    assign accept   = start && (state_reg == ST_IDLE);
    assign one_left = (dig_cnt_reg == DIG_CNT_W'(1));

    sbda_bcd_core u_bcd (
        .clk  (clk),
        .op   (op),
        .mag  (mag),
        .stat (stat)
    );

    // Sequencer: load, convert bit by bit, sign, skip leading zeros, emit.
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        valid_next     = 1'b0;
        character_next = character_reg;
        last_next      = last_reg;
        op             = BCD_HOLD;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op           = BCD_LOAD;
                    neg_next     = value[VALUE_BITS-1];
                    bit_cnt_next = BIT_CNT_W'(VALUE_BITS - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                op = BCD_DABBLE;
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_CNT_W'(DIGIT_SLOTS);
                    state_next   = neg_reg ? ST_SIGN : ST_SKIP;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                end
            end
            ST_SIGN:
            begin
                valid_next     = 1'b1;
                character_next = CHAR_MINUS;
                last_next      = 1'b0;
                state_next     = ST_SKIP;
            end
            ST_SKIP:
            begin
                if (stat.top_zero && !one_left)
                begin
                    op           = BCD_SHIFT;
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                op             = BCD_SHIFT;
                valid_next     = 1'b1;
                character_next = CHAR_ZERO + {4'd0, stat.top_digit};
                last_next      = one_left;
                dig_cnt_next   = dig_cnt_reg - DIG_CNT_W'(1);
                if (one_left)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Payload and counters.
    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        bit_cnt_reg   <= bit_cnt_next;
        dig_cnt_reg   <= dig_cnt_next;
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign valid     = valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

    // A character only follows a cycle in which the block was working.
    a_valid_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("character emitted outside a conversion");

    // An accepted beat always starts a conversion.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start a conversion");

    // The final character ends the burst.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last) |=> !valid)
        else $error("character emitted right after the last one");

    // A minus sign is never the final character.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (character == CHAR_MINUS)) |-> !last)
        else $error("minus sign flagged as last");

endmodule
